// ===== rtl/dsdw_pkg.sv =====
`default_nettype none
package dsdw_pkg;

   localparam int NUM_DIGITS = 6;
   localparam int POS_W      = 3;
   localparam int ADDR_W     = 5;
   localparam int DIGIT_W    = 4;
   localparam int REST_W     = 20;
   localparam int SEG_W      = 8;

   localparam logic [31:0]      LIMIT_VALUE = 32'd1000000;
   localparam logic [POS_W-1:0] LAST_POS    = POS_W'(NUM_DIGITS - 1);

   // Decimal weight of each character position, leftmost first.
   localparam logic [REST_W-1:0] POW10 [NUM_DIGITS] = '{
      20'd100000, 20'd10000, 20'd1000, 20'd100, 20'd10, 20'd1
   };

   localparam logic [ADDR_W-1:0] ADDR_OF_POS [NUM_DIGITS] = '{
      5'd4, 5'd6, 5'd8, 5'd10, 5'd2, 5'd18
   };

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [REST_W-1:0]  rem;
   } digit_step_type;

   typedef struct packed {
      logic [SEG_W-1:0] high;
      logic [SEG_W-1:0] low;
   } seg_pair_type;

   // One decimal digit off the top of rest. The nine compares are
   // independent; the running multiple folds to constants for a fixed k.
   function automatic digit_step_type digit_step(input logic [REST_W-1:0] rest,
                                                 input int k);
      digit_step_type     r;
      logic [REST_W-1:0]  m;
      logic [REST_W-1:0]  sel;
      r.digit = '0;
      m       = '0;
      sel     = '0;
      for (int j = 1; j <= 9; j++) begin
         m = m + POW10[k];
         if (rest >= m) begin
            r.digit = DIGIT_W'(j);
            sel     = m;
         end
      end
      r.rem = rest - sel;
      return r;
   endfunction

   function automatic seg_pair_type seg_digit(input logic [DIGIT_W-1:0] d);
      seg_pair_type s;
      case (d)
         4'd0:    s = '{high: 8'h28, low: 8'hFC};
         4'd1:    s = '{high: 8'h20, low: 8'h60};
         4'd2:    s = '{high: 8'h00, low: 8'hDB};
         4'd3:    s = '{high: 8'h00, low: 8'hF3};
         4'd4:    s = '{high: 8'h00, low: 8'h67};
         4'd5:    s = '{high: 8'h00, low: 8'hB7};
         4'd6:    s = '{high: 8'h00, low: 8'hBF};
         4'd7:    s = '{high: 8'h00, low: 8'hE4};
         4'd8:    s = '{high: 8'h00, low: 8'hFF};
         default: s = '{high: 8'h00, low: 8'hF7};
      endcase
      return s;
   endfunction

   // Segment pairs that spell " ERROR".
   function automatic seg_pair_type seg_error(input logic [POS_W-1:0] pos);
      seg_pair_type s;
      case (pos)
         3'd0:    s = '{high: 8'h00, low: 8'h00};
         3'd1:    s = '{high: 8'h00, low: 8'h9F};
         3'd4:    s = '{high: 8'h00, low: 8'hFC};
         default: s = '{high: 8'h02, low: 8'hCF};
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/decimal_segment_display_writer_core.sv =====
`default_nettype none
// Decimal segment display writer.
//
// A command beat is taken on the rising edge where start is high and busy
// is low; req_value carries the number to show. Each command yields six
// display-memory write beats on the rsp_ ports, positions 0 through 5 from
// left to right. Every beat is valid for exactly one cycle, flagged by
// rsp_strobe, and rsp_last marks the sixth beat. Values of one million or
// more spell " ERROR"; smaller values show in decimal with leading zeros
// blanked, the rightmost digit always shown.
//
// A command moves through the digit pipeline stages into the serializer;
// its beats leave through the result registers in consecutive cycles. A
// six-stage digit pipeline feeds a serializer that drives one beat per
// cycle, so the sustained command rate is set by the single write beat per
// cycle on the result side. Commands may arrive back to back; busy rises
// once the pipeline fills behind the serializer and falls as it drains.
//
// Reset clears every valid bit and the strobe; no beat is pending after it.
// The receiver cannot stall, so each beat is taken in the cycle it shows.
module decimal_segment_display_writer_core
   import dsdw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [31:0]       req_value,
   output logic                   rsp_strobe,
   output logic [POS_W-1:0]       rsp_position,
   output logic [ADDR_W-1:0]      rsp_mem_address,
   output logic [SEG_W-1:0]       rsp_segments_low,
   output logic [SEG_W-1:0]       rsp_segments_high,
   output logic                   rsp_last
);

   localparam int NS = NUM_DIGITS;

   // Pipeline stage i holds the remainder after digits 0..i-1 are taken.
   logic                valid_ff [NS];
   logic                err_ff   [NS];
   logic [REST_W-1:0]   rest_ff  [NS];
   logic [DIGIT_W-1:0]  dig_ff   [NS][NS-1];
   logic                stage_rdy [NS];
   digit_step_type      step_c    [NS];

   // Serializer state: one value being written out one position a cycle.
   logic                ser_active_ff;
   logic [POS_W-1:0]    ser_pos_ff;
   logic                ser_err_ff;
   logic                ser_shown_ff;
   logic [DIGIT_W-1:0]  ser_dig_ff [NS];
   logic                ser_take;
   logic                ser_load;

   // Registered result beat.
   logic                rsp_strobe_ff;
   logic [POS_W-1:0]    rsp_position_ff;
   logic [ADDR_W-1:0]   rsp_mem_address_ff;
   seg_pair_type        rsp_seg_ff;
   logic                rsp_last_ff;

   logic [DIGIT_W-1:0]  cur_digit;
   logic                cur_blank;
   seg_pair_type        cur_seg_in;

   assign step_c[0] = '0;
   for (genvar i = 1; i < NS; i++) begin : g_step
      assign step_c[i] = digit_step(rest_ff[i-1], i - 1);
   end

   // A stage can take new data when it is empty or its content moves on.
   assign ser_take = !ser_active_ff || (ser_pos_ff == LAST_POS);
   assign ser_load = valid_ff[NS-1] && ser_take;

   always_comb begin
      stage_rdy[NS-1] = !valid_ff[NS-1] || ser_take;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_rdy[i] = !valid_ff[i] || stage_rdy[i+1];
      end
   end

   assign busy = !stage_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (stage_rdy[0]) begin
            valid_ff[0] <= start;
            err_ff[0]   <= (req_value >= LIMIT_VALUE);
            rest_ff[0]  <= req_value[REST_W-1:0];
            for (int j = 0; j < NS - 1; j++) begin
               dig_ff[0][j] <= '0;
            end
         end
         for (int i = 1; i < NS; i++) begin
            if (stage_rdy[i]) begin
               valid_ff[i] <= valid_ff[i-1];
               err_ff[i]   <= err_ff[i-1];
               rest_ff[i]  <= step_c[i].rem;
               for (int j = 0; j < NS - 1; j++) begin
                  if (j == i - 1) begin
                     dig_ff[i][j] <= step_c[i].digit;
                  end else begin
                     dig_ff[i][j] <= dig_ff[i-1][j];
                  end
               end
            end
         end
      end
   end

   // Character for the current position. A zero is blanked until the
   // first nonzero digit, except in the rightmost position.
   always_comb begin
      cur_digit = ser_dig_ff[ser_pos_ff];
      cur_blank = !ser_shown_ff && (cur_digit == '0) && (ser_pos_ff != LAST_POS);
      if (ser_err_ff) begin
         cur_seg_in = seg_error(ser_pos_ff);
      end else if (cur_blank) begin
         cur_seg_in = '0;
      end else begin
         cur_seg_in = seg_digit(cur_digit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_active_ff <= 1'b0;
      end else if (ser_load) begin
         ser_active_ff <= 1'b1;
         ser_pos_ff    <= '0;
         ser_shown_ff  <= 1'b0;
         ser_err_ff    <= err_ff[NS-1];
         for (int j = 0; j < NS - 1; j++) begin
            ser_dig_ff[j] <= dig_ff[NS-1][j];
         end
         ser_dig_ff[NS-1] <= rest_ff[NS-1][DIGIT_W-1:0];
      end else if (ser_active_ff) begin
         if (ser_pos_ff == LAST_POS) begin
            ser_active_ff <= 1'b0;
         end else begin
            ser_pos_ff   <= ser_pos_ff + 1'b1;
            ser_shown_ff <= ser_shown_ff || !cur_blank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ser_active_ff;
      end
      rsp_position_ff    <= ser_pos_ff;
      rsp_mem_address_ff <= ADDR_OF_POS[ser_pos_ff];
      rsp_seg_ff         <= cur_seg_in;
      rsp_last_ff        <= (ser_pos_ff == LAST_POS);
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_mem_address   = rsp_mem_address_ff;
   assign rsp_segments_low  = rsp_seg_ff.low;
   assign rsp_segments_high = rsp_seg_ff.high;
   assign rsp_last          = rsp_last_ff;

endmodule
`default_nettype wire
